### design/mjpid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mjpid_pkg;

	localparam int JOINT_COUNT_DEF = 8;
	localparam int DATA_W = 32;
	localparam int LIMIT_W = 31;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
	localparam logic [2:0] REG_INTEG_GAIN    = 3'd1;
	localparam logic [2:0] REG_DERIV_GAIN    = 3'd2;
	localparam logic [2:0] REG_INTEG_LIMIT   = 3'd3;
	localparam logic [2:0] REG_TORQUE_LIMIT  = 3'd4;
	localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd5;

	// Operation codes of an input item.
	localparam logic [1:0] FUNC_COMPUTE = 2'd0;
	localparam logic [1:0] FUNC_SET     = 2'd1;
	localparam logic [1:0] FUNC_CLEAR   = 2'd2;

	// Datapath step codes issued by the controller.
	localparam logic [3:0] STEP_NONE   = 4'd0;
	localparam logic [3:0] STEP_LOAD   = 4'd1;
	localparam logic [3:0] STEP_MUL_EP = 4'd2;
	localparam logic [3:0] STEP_INT    = 4'd3;
	localparam logic [3:0] STEP_MUL_P  = 4'd4;
	localparam logic [3:0] STEP_MUL_I  = 4'd5;
	localparam logic [3:0] STEP_ACC    = 4'd6;
	localparam logic [3:0] STEP_DSAT   = 4'd7;
	localparam logic [3:0] STEP_MUL_D  = 4'd8;
	localparam logic [3:0] STEP_FIN    = 4'd9;

	localparam logic [5:0] DIV_STEPS = 6'd49;

	typedef struct packed {
		logic       capture;
		logic [3:0] step;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic is_compute;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

### design/mjpid_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module mjpid_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  mjpid_pkg::sts_t      sts,
	output mjpid_pkg::cmd_t      cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_LOAD  = 4'd1;
	localparam logic [3:0] S_MEP   = 4'd2;
	localparam logic [3:0] S_INT   = 4'd3;
	localparam logic [3:0] S_MP    = 4'd4;
	localparam logic [3:0] S_AP    = 4'd5;
	localparam logic [3:0] S_MI    = 4'd6;
	localparam logic [3:0] S_AI    = 4'd7;
	localparam logic [3:0] S_WAIT  = 4'd8;
	localparam logic [3:0] S_DSAT  = 4'd9;
	localparam logic [3:0] S_MD    = 4'd10;
	localparam logic [3:0] S_AD    = 4'd11;
	localparam logic [3:0] S_FIN   = 4'd12;
	localparam logic [3:0] S_DONE  = 4'd13;

	logic [3:0] state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd.capture = 1'b0;
		cmd.step = mjpid_pkg::STEP_NONE;
		cmd.out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.step = mjpid_pkg::STEP_LOAD;
				state_d = S_MEP;
			end
			S_MEP: begin
				// The item kind is known from the captured fields here.
				if (sts.is_compute) begin
					cmd.step = mjpid_pkg::STEP_MUL_EP;
					state_d = S_INT;
				end else begin
					state_d = S_DONE;
				end
			end
			S_INT: begin
				cmd.step = mjpid_pkg::STEP_INT;
				state_d = S_MP;
			end
			S_MP: begin
				cmd.step = mjpid_pkg::STEP_MUL_P;
				state_d = S_AP;
			end
			S_AP: begin
				cmd.step = mjpid_pkg::STEP_ACC;
				state_d = S_MI;
			end
			S_MI: begin
				cmd.step = mjpid_pkg::STEP_MUL_I;
				state_d = S_AI;
			end
			S_AI: begin
				cmd.step = mjpid_pkg::STEP_ACC;
				state_d = S_WAIT;
			end
			S_WAIT: begin
				if (sts.div_done) begin
					state_d = S_DSAT;
				end
			end
			S_DSAT: begin
				cmd.step = mjpid_pkg::STEP_DSAT;
				state_d = S_MD;
			end
			S_MD: begin
				cmd.step = mjpid_pkg::STEP_MUL_D;
				state_d = S_AD;
			end
			S_AD: begin
				cmd.step = mjpid_pkg::STEP_ACC;
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd.step = mjpid_pkg::STEP_FIN;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

### design/mjpid_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module mjpid_dp #(
	parameter int JOINT_COUNT = mjpid_pkg::JOINT_COUNT_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  mjpid_pkg::cmd_t          cmd,
	output mjpid_pkg::sts_t          sts,
	input  wire logic [1:0]          func,
	input  wire logic [3:0]          joint,
	input  wire logic signed [31:0]  target_angle,
	input  wire logic signed [31:0]  measured_angle,
	input  wire logic signed [31:0]  set_value,
	input  wire logic signed [31:0]  prop_gain,
	input  wire logic signed [31:0]  integ_gain,
	input  wire logic signed [31:0]  deriv_gain,
	input  wire logic [30:0]         integ_limit,
	input  wire logic [30:0]         torque_limit,
	input  wire logic [30:0]         sample_period,
	input  wire logic                out_stall,
	output logic                     out_valid,
	output logic signed [31:0]       torque,
	output logic                     bad_index
);

	localparam int IDX_W = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
	localparam logic [4:0] JC_V = 5'(JOINT_COUNT);

	logic [1:0]         func_q;
	logic [3:0]         joint_q;
	logic signed [31:0] target_q, measured_q, setv_q;

	logic signed [31:0] integ_mem [JOINT_COUNT];
	logic signed [31:0] last_mem [JOINT_COUNT];

	logic signed [31:0] err_q, old_q, integ_q, deriv_q, res_torque_q;
	logic               res_bad_q;
	logic signed [63:0] prod_q;
	logic signed [49:0] acc_q;

	logic [48:0] dq_q;
	logic [30:0] rem_q;
	logic [30:0] dper_q;
	logic        dneg_q;
	logic [5:0]  cnt_q;

	logic               joint_ok;
	logic [IDX_W-1:0]   idx;
	logic signed [32:0] diff33;
	logic signed [31:0] err_sat;
	logic signed [32:0] ediff;
	logic signed [48:0] dvd;
	logic [48:0]        dvd_mag;
	logic [31:0]        rem_sh;
	logic [32:0]        trial;
	logic signed [31:0] mul_a, mul_b;
	logic signed [47:0] prod_sh;
	logic signed [48:0] integ_sum;
	logic signed [48:0] ilim;
	logic signed [49:0] tlim;
	logic signed [31:0] torque_fin;
	logic signed [31:0] deriv_sat;

	assign joint_ok = ({1'b0, joint_q} < JC_V);
	assign idx = joint_q[IDX_W-1:0];

	assign sts.is_compute = (func_q == mjpid_pkg::FUNC_COMPUTE) && joint_ok;
	assign sts.div_done = (cnt_q == 6'd0);
	assign sts.out_free = !out_valid || !out_stall;

	always_comb begin
		diff33 = 33'(target_q) - 33'(measured_q);
		if (diff33 > 33'sd2147483647) begin
			err_sat = 32'sh7FFFFFFF;
		end else if (diff33 < -33'sd2147483648) begin
			err_sat = 32'sh80000000;
		end else begin
			err_sat = diff33[31:0];
		end
		ediff = 33'(err_sat) - 33'(last_mem[idx]);
		dvd = {ediff[32], ediff[31:0], 16'd0};
		dvd_mag = dvd[48] ? 49'(-dvd) : 49'(dvd);
		rem_sh = {rem_q, dq_q[48]};
		trial = {1'b0, rem_sh} - {2'b0, dper_q};
		prod_sh = prod_q[63:16];
		integ_sum = 49'(old_q) + 49'(prod_sh);
		ilim = 49'($signed({1'b0, integ_limit}));
		tlim = 50'($signed({1'b0, torque_limit}));
		if (dneg_q) begin
			deriv_sat = (dq_q > 49'd2147483648) ? 32'sh80000000 : 32'(-$signed(dq_q));
		end else begin
			deriv_sat = (dq_q > 49'd2147483647) ? 32'sh7FFFFFFF : $signed(dq_q[31:0]);
		end
		if (torque_limit != 31'd0) begin
			if (acc_q > tlim) begin
				torque_fin = 32'(tlim);
			end else if (acc_q < -tlim) begin
				torque_fin = 32'(-tlim);
			end else begin
				torque_fin = acc_q[31:0];
			end
		end else if (acc_q > 50'sd2147483647) begin
			torque_fin = 32'sh7FFFFFFF;
		end else if (acc_q < -50'sd2147483648) begin
			torque_fin = 32'sh80000000;
		end else begin
			torque_fin = acc_q[31:0];
		end
		case (cmd.step)
			mjpid_pkg::STEP_MUL_EP: begin
				mul_a = err_q;
				mul_b = $signed({1'b0, sample_period});
			end
			mjpid_pkg::STEP_MUL_P: begin
				mul_a = prop_gain;
				mul_b = err_q;
			end
			mjpid_pkg::STEP_MUL_I: begin
				mul_a = integ_gain;
				mul_b = integ_q;
			end
			default: begin
				mul_a = deriv_gain;
				mul_b = deriv_q;
			end
		endcase
	end

	// Captured item fields.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			joint_q <= joint;
			target_q <= target_angle;
			measured_q <= measured_angle;
			setv_q <= set_value;
		end
	end

	// Joint state, cleared by reset and by the clear operation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < JOINT_COUNT; i++) begin
				integ_mem[i] <= '0;
				last_mem[i] <= '0;
			end
		end else begin
			if (cmd.step == mjpid_pkg::STEP_LOAD) begin
				if (func_q == mjpid_pkg::FUNC_CLEAR) begin
					for (int i = 0; i < JOINT_COUNT; i++) begin
						integ_mem[i] <= '0;
						last_mem[i] <= '0;
					end
				end else if (func_q == mjpid_pkg::FUNC_SET && joint_ok) begin
					integ_mem[idx] <= setv_q;
				end
			end
			if (cmd.step == mjpid_pkg::STEP_INT) begin
				if (integ_sum > ilim) begin
					integ_mem[idx] <= 32'(ilim);
				end else if (integ_sum < -ilim) begin
					integ_mem[idx] <= 32'(-ilim);
				end else begin
					integ_mem[idx] <= integ_sum[31:0];
				end
			end
			if (cmd.step == mjpid_pkg::STEP_FIN) begin
				last_mem[idx] <= err_q;
			end
		end
	end

	// Arithmetic registers.
	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
		case (cmd.step)
			mjpid_pkg::STEP_LOAD: begin
				err_q <= err_sat;
				old_q <= integ_mem[idx];
				acc_q <= '0;
				res_torque_q <= '0;
				res_bad_q <= (func_q == mjpid_pkg::FUNC_COMPUTE
					|| func_q == mjpid_pkg::FUNC_SET) && !joint_ok;
			end
			mjpid_pkg::STEP_INT: begin
				if (integ_sum > ilim) begin
					integ_q <= 32'(ilim);
				end else if (integ_sum < -ilim) begin
					integ_q <= 32'(-ilim);
				end else begin
					integ_q <= integ_sum[31:0];
				end
			end
			mjpid_pkg::STEP_ACC: begin
				acc_q <= acc_q + 50'(prod_sh);
			end
			mjpid_pkg::STEP_DSAT: begin
				deriv_q <= deriv_sat;
			end
			mjpid_pkg::STEP_FIN: begin
				res_torque_q <= torque_fin;
			end
			default: begin
			end
		endcase
	end

	// Restoring divider, one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.step == mjpid_pkg::STEP_LOAD) begin
			cnt_q <= mjpid_pkg::DIV_STEPS;
		end else if (cnt_q != 6'd0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step == mjpid_pkg::STEP_LOAD) begin
			dq_q <= dvd_mag;
			rem_q <= '0;
			dneg_q <= dvd[48];
			dper_q <= (sample_period == 31'd0) ? 31'd1 : sample_period;
		end else if (cnt_q != 6'd0) begin
			if (!trial[32]) begin
				rem_q <= trial[30:0];
				dq_q <= {dq_q[47:0], 1'b1};
			end else begin
				rem_q <= rem_sh[30:0];
				dq_q <= {dq_q[47:0], 1'b0};
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			torque <= res_torque_q;
			bad_index <= res_bad_q;
		end
	end

endmodule
`default_nettype wire

### design/multi_joint_pid_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake                  Payload
// input     in_valid / in_stall        func, joint, target_angle, measured_angle, set_value
// output    out_valid / out_stall      torque, bad_index
// config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// A compute item waits on the 49-step restoring divider for the derivative before
// its result is ready, while the shared 32x32 multiplier works on the integral and
// the first two gain terms alongside it. Set, clear and bad-index items skip the
// arithmetic steps. One item is worked at a time.
// Reset clears the joint state and loads the register defaults at once.
// The result sits in an output register, so a new item is taken while it is stalled.
module multi_joint_pid_controller #(
	parameter int JOINT_COUNT = mjpid_pkg::JOINT_COUNT_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         func,
	input  wire logic [3:0]         joint,
	input  wire logic signed [31:0] target_angle,
	input  wire logic signed [31:0] measured_angle,
	input  wire logic signed [31:0] set_value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      torque,
	output logic                    bad_index,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	mjpid_pkg::cmd_t cmd;
	mjpid_pkg::sts_t sts;

	// Configuration registers; the user must write them only while no item is in flight (the block does not enforce it).
	logic signed [31:0] prop_gain_q, integ_gain_q, deriv_gain_q;
	logic [30:0]        integ_limit_q, torque_limit_q, sample_period_q;
	logic [2:0]         reg_idx;
	logic               wr_en;

	assign pready = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q <= '0;
			integ_gain_q <= '0;
			deriv_gain_q <= '0;
			integ_limit_q <= 31'h7FFFFFFF;
			torque_limit_q <= '0;
			sample_period_q <= 31'h10000;
		end else if (wr_en) begin
			case (reg_idx)
				mjpid_pkg::REG_PROP_GAIN:     prop_gain_q <= pwdata;
				mjpid_pkg::REG_INTEG_GAIN:    integ_gain_q <= pwdata;
				mjpid_pkg::REG_DERIV_GAIN:    deriv_gain_q <= pwdata;
				mjpid_pkg::REG_INTEG_LIMIT:   integ_limit_q <= pwdata[30:0];
				mjpid_pkg::REG_TORQUE_LIMIT:  torque_limit_q <= pwdata[30:0];
				mjpid_pkg::REG_SAMPLE_PERIOD: sample_period_q <= pwdata[30:0];
				default: begin
				end
			endcase
		end
	end

	// Read back: the unsigned limits come back zero-extended.
	always_comb begin
		unique case (reg_idx)
			mjpid_pkg::REG_PROP_GAIN:     prdata = prop_gain_q;
			mjpid_pkg::REG_INTEG_GAIN:    prdata = integ_gain_q;
			mjpid_pkg::REG_DERIV_GAIN:    prdata = deriv_gain_q;
			mjpid_pkg::REG_INTEG_LIMIT:   prdata = {1'b0, integ_limit_q};
			mjpid_pkg::REG_TORQUE_LIMIT:  prdata = {1'b0, torque_limit_q};
			mjpid_pkg::REG_SAMPLE_PERIOD: prdata = {1'b0, sample_period_q};
			default:                      prdata = '0;
		endcase
	end

	// For a compute item the controller sequences the datapath through load, integral
	// update, the three gain products, the derivative clamp and the final clamp.
	mjpid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	mjpid_dp #(
		.JOINT_COUNT (JOINT_COUNT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.func           (func),
		.joint          (joint),
		.target_angle   (target_angle),
		.measured_angle (measured_angle),
		.set_value      (set_value),
		.prop_gain      (prop_gain_q),
		.integ_gain     (integ_gain_q),
		.deriv_gain     (deriv_gain_q),
		.integ_limit    (integ_limit_q),
		.torque_limit   (torque_limit_q),
		.sample_period  (sample_period_q),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.torque         (torque),
		.bad_index      (bad_index)
	);

endmodule
`default_nettype wire
